/* rtl/mltt_pkg.sv */
// Shared types and constants of the multi-level threshold trigger.
package mltt_pkg;

	// Field widths
	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 16;
	localparam int OFFSET_W  = 20;
	localparam int VAL_W     = 24;
	localparam int PROD_W    = SAMPLE_W + GAIN_W;
	localparam int LEVEL_W   = 16;
	localparam int MODE_W    = 3;
	localparam int NUM_SLOTS = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	// Saturation bounds of the scaled value
	localparam logic signed [VAL_W:0] VAL_MAX = (VAL_W+1)'(2 ** (VAL_W - 1) - 1);
	localparam logic signed [VAL_W:0] VAL_MIN = -(VAL_W+1)'(2 ** (VAL_W - 1));

	// Reset value of the gain, 1.0 in Q7.8
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

	// Channel mode codes
	typedef enum logic [MODE_W-1:0] {
		MODE_OFF     = 3'd0,
		MODE_RISING  = 3'd1,
		MODE_FALLING = 3'd2,
		MODE_HIGH    = 3'd3,
		MODE_LOW     = 3'd4
	} mode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN      = 3'd0,
		REG_OFFSET    = 3'd1,
		REG_MODES     = 3'd2,
		REG_LEVELS_LO = 3'd3,
		REG_LEVELS_HI = 3'd4
	} cfg_reg_t;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [NUM_SLOTS-1:0][MODE_W-1:0] modes_t;
	typedef logic [NUM_SLOTS-1:0][LEVEL_W-1:0] levels_t;

endpackage

/* rtl/mltt_front.sv */
// Front end: accepts samples, multiplies by the gain, shifts, adds offset, saturates.
module mltt_front import mltt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [GAIN_W-1:0]   gain,
	input  logic signed [OFFSET_W-1:0] offset,
	output logic                       push_valid,
	input  logic                       push_ready,
	output value_t                     push_data
);

	logic                     v_s1;
	logic                     v_s2;
	logic signed [PROD_W-1:0] product_s1;
	value_t                   value_s2;
	logic                     adv1;
	logic                     adv2;
	logic signed [VAL_W-1:0]  shifted;
	logic signed [VAL_W:0]    sum;
	value_t                   value_sat;

	// Stage advance: a stage moves when it is empty or the next one takes its item
	assign adv2     = !v_s2 || push_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1: product
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			product_s1 <= PROD_W'(sample) * PROD_W'(gain);
		end
	end

	// Floor shift by 8 is dropping the low byte; then offset and clamp
	always_comb begin
		shifted = product_s1[PROD_W-1:PROD_W-VAL_W];
		sum     = (VAL_W+1)'(shifted) + (VAL_W+1)'(offset);
		if (sum > VAL_MAX) begin
			value_sat = VAL_MAX[VAL_W-1:0];
		end else if (sum < VAL_MIN) begin
			value_sat = VAL_MIN[VAL_W-1:0];
		end else begin
			value_sat = sum[VAL_W-1:0];
		end
	end

	// Stage 2: scaled value
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			value_s2 <= value_sat;
		end
	end

	assign push_valid = v_s2;
	assign push_data  = value_s2;

endmodule

/* rtl/mltt_queue.sv */
// Small FIFO of scaled values between the front and back ends.
module mltt_queue import mltt_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  value_t push_data,
	output logic   pop_valid,
	input  logic   pop_ready,
	output value_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	value_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/mltt_back.sv */
// Back end: per-channel threshold compare against current and previous value.
module mltt_back import mltt_pkg::*; #(
	parameter int CHANNELS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  value_t               pop_data,
	input  modes_t               modes,
	input  levels_t              levels,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [NUM_SLOTS-1:0] triggers
);

	logic                 out_valid_q;
	logic [NUM_SLOTS-1:0] triggers_q;
	value_t               prev_q;
	logic                 have_prev_q;
	logic                 take;
	logic [NUM_SLOTS-1:0] hits;
	value_t               thr;

	assign pop_ready = !out_valid_q || !out_stall;
	assign take      = pop_valid && pop_ready;

	// Channel conditions, each channel on its own
	always_comb begin
		hits = '0;
		thr  = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			thr = VAL_W'(signed'(levels[i]));
			if (i < CHANNELS && have_prev_q) begin
				unique case (mode_t'(modes[i]))
					MODE_RISING:  hits[i] = (prev_q < thr) && (pop_data >= thr);
					MODE_FALLING: hits[i] = (prev_q > thr) && (pop_data <= thr);
					MODE_HIGH:    hits[i] = pop_data > thr;
					MODE_LOW:     hits[i] = pop_data < thr;
					default:      hits[i] = 1'b0;
				endcase
			end
		end
	end

	// Output register and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
		end else begin
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
			if (take) begin
				have_prev_q <= 1'b1;
				prev_q      <= pop_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			triggers_q <= hits;
		end
	end

	assign out_valid = out_valid_q;
	assign triggers  = triggers_q;

endmodule

/* rtl/multi_level_threshold_trigger_unit.sv */
// Multi-level threshold trigger: top level with configuration registers.
//
// Usage:
//   Input channel (in_valid, in_stall, sample): one signed Q3.12 sample per
//   transfer. Output channel (out_valid, out_stall, triggers): one six-bit
//   trigger vector per sample, in sample order.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index
//   0 gain, 1 offset, 2 channel modes, 3 levels of channels 0-3, 4 levels of
//   channels 4-5; other indexes are ignored. cfg_ready is always high; write
//   only while no sample is in flight.
//   Pipeline: a result passes the multiply stage, the scale/saturate stage,
//   the queue and the output register. Throughput: one sample per cycle
//   while in_stall is low, set by the single multiplier stage.
//   Reset: registers go to gain 1.0, offset 0, all channels inactive, levels
//   0; the first sample after reset yields an all-zero trigger vector.
//   Stall: a held result stays stable; the queue absorbs up to QUEUE_DEPTH
//   values plus the two front stages before in_stall rises.
module multi_level_threshold_trigger_unit import mltt_pkg::*; #(
	parameter int CHANNELS    = 6,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [NUM_SLOTS-1:0]       triggers,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DAT_W-1:0]       cfg_data
);

	logic [GAIN_W-1:0]          gain_q;
	logic [OFFSET_W-1:0]        offset_q;
	logic [NUM_SLOTS*MODE_W-1:0] modes_q;
	logic [4*LEVEL_W-1:0]       levels_lo_q;
	logic [2*LEVEL_W-1:0]       levels_hi_q;
	logic                       push_valid;
	logic                       push_ready;
	value_t                     push_data;
	logic                       pop_valid;
	logic                       pop_ready;
	value_t                     pop_data;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_RESET;
			offset_q    <= '0;
			modes_q     <= '0;
			levels_lo_q <= '0;
			levels_hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN:      gain_q      <= cfg_data[GAIN_W-1:0];
				REG_OFFSET:    offset_q    <= cfg_data[OFFSET_W-1:0];
				REG_MODES:     modes_q     <= cfg_data[NUM_SLOTS*MODE_W-1:0];
				REG_LEVELS_LO: levels_lo_q <= cfg_data[4*LEVEL_W-1:0];
				REG_LEVELS_HI: levels_hi_q <= cfg_data[2*LEVEL_W-1:0];
				default:       ;
			endcase
		end
	end

	mltt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.gain       (signed'(gain_q)),
		.offset     (signed'(offset_q)),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mltt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mltt_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.modes     (modes_t'(modes_q)),
		.levels    (levels_t'({levels_hi_q, levels_lo_q})),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.triggers  (triggers)
	);

endmodule

/* rtl/mltt_checker.sv */
// Port-level checker of the threshold trigger and its bind.
module mltt_checker import mltt_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [NUM_SLOTS-1:0] triggers
);

	localparam int MAX_PENDING = QUEUE_DEPTH + 3;

	logic [7:0] pending_q;
	logic       seen_out_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// Samples taken but not yet delivered, and first-result tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			seen_out_q <= 1'b0;
		end else begin
			pending_q <= pending_q + 8'(in_xfer) - 8'(out_xfer);
			if (out_xfer) begin
				seen_out_q <= 1'b1;
			end
		end
	end

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(triggers))
		else $error("result changed while stalled");

	// No result without a sample behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("result without a pending sample");

	// Storage in flight is bounded
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 8'(MAX_PENDING))
		else $error("more samples in flight than the pipeline holds");

	// The first result after reset never fires
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen_out_q |-> triggers == '0)
		else $error("trigger on first sample after reset");

endmodule

bind multi_level_threshold_trigger_unit mltt_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_mltt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.triggers  (triggers)
);
